// ===== src/rzs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rzs_pkg;

  localparam int MAX_ZONES   = 8;
  localparam int ZONE_OFFSET = 2;
  localparam int ZONE_W      = 3;
  localparam int ZCNT_W      = 4;
  localparam int LIMIT_W     = 16;
  localparam int COL_W       = 16;
  localparam int CELL_W      = 8;
  localparam int DIST_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 32;

  localparam logic [DIST_W-1:0] DIST_SAT    = {DIST_W{1'b1}};
  localparam logic [CELL_W-1:0] SOURCE_MARK = CELL_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_LOW  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_HIGH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SQUARED     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_WRAP        = CFG_IDX_W'(5);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_CELL  = 1'b1;

  typedef enum logic [1:0] {
    STOP_RUN    = 2'd0,
    STOP_EDGE   = 2'd1,
    STOP_SOURCE = 2'd2,
    STOP_FAR    = 2'd3
  } stop_t;

  typedef struct packed {
    logic [ZCNT_W-1:0]                   zone_count;
    logic [MAX_ZONES-1:0][LIMIT_W-1:0]   limits;
    logic                                squared_mode;
    logic [COL_W-1:0]                    column_count;
    logic [COL_W-1:0]                    wrap_columns;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [COL_W-1:0]  start_column;
    logic [ZONE_W-1:0] start_zone;
    logic [CELL_W-1:0] source_cell;
    logic [CELL_W-1:0] target_cell;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] new_cell;
    logic              cell_written;
    logic [COL_W-1:0]  next_column;
    stop_t             stop_reason;
  } result_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_SAT : s[DIST_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/raster_zone_scan_right.sv =====
// Rightward distance-zone scan over one raster row.
// Input stream s_*: tuser carries func (0 start item, 1 cell item); tdata
// carries start_column, start_zone, source_cell and target_cell. A start item
// opens a scan; each cell item brings the next column of the source row and
// the zone code of the same column in the target row.
// Output stream m_*: one result per accepted item, in order: updated zone
// code, write flag, next column to feed and the stop reason.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle,
// only while no item is in flight (user rule; the block does not enforce it).
// Each item passes the input register and then the output register before
// its result is presented on m_tvalid.
// Throughput: one item per cycle while m_tready is high; the scan state
// updates once per item in a step stage between input and output registers.
// Reset (rst, synchronous): clears both stages, closes any scan and restores
// the default registers.
// Stall: while m_tready is low the result holds; the input register still
// takes one more item, then s_tready drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none
module raster_zone_scan_right (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // start_column[15:0], start_zone[18:16], source_cell[26:19],
  // target_cell[34:27], zero pad[39:35]
  input  wire logic [rzs_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[0]
  input  wire logic                           s_tuser,
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  // new_cell[7:0], cell_written[8], next_column[24:9], stop_reason[26:25],
  // zero pad[31:27]
  output      logic [rzs_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rzs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rzs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rzs_pkg::cfg_t    cfg;
  rzs_pkg::item_t   in_item;
  rzs_pkg::result_t step_res;
  rzs_pkg::result_t out_res;
  logic             in_valid;
  logic             step_fire;

  rzs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign step_fire = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func         <= s_tuser;
      in_item.start_column <= s_tdata[15:0];
      in_item.start_zone   <= s_tdata[18:16];
      in_item.source_cell  <= s_tdata[26:19];
      in_item.target_cell  <= s_tdata[34:27];
    end
  end

  rzs_step u_step (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (step_fire),
    .item (in_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {5'b0, out_res.stop_reason, out_res.next_column,
                    out_res.cell_written, out_res.new_cell};

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("stages not cleared by reset");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");

  a_write_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.cell_written |->
      out_res.new_cell >= 8'(rzs_pkg::ZONE_OFFSET) &&
      out_res.new_cell < 8'(rzs_pkg::ZONE_OFFSET + rzs_pkg::MAX_ZONES))
    else $error("written zone code out of range");

  a_write_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.cell_written |->
      out_res.stop_reason == rzs_pkg::STOP_RUN ||
      out_res.stop_reason == rzs_pkg::STOP_EDGE)
    else $error("cell written on a source or far stop");

endmodule
`default_nettype wire

// ===== src/rzs_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rzs_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rzs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rzs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output rzs_pkg::cfg_t                         cfg
);

  logic [rzs_pkg::ZCNT_W-1:0]     zone_count;
  logic [rzs_pkg::CFG_DATA_W-1:0] limits_low;
  logic [rzs_pkg::CFG_DATA_W-1:0] limits_high;
  logic                           squared_mode;
  logic [rzs_pkg::COL_W-1:0]      column_count;
  logic [rzs_pkg::COL_W-1:0]      wrap_columns;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count   <= rzs_pkg::ZCNT_W'(1);
      limits_low   <= '0;
      limits_high  <= '0;
      squared_mode <= 1'b1;
      column_count <= rzs_pkg::COL_W'(1024);
      wrap_columns <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rzs_pkg::REG_ZONE_COUNT:  zone_count   <= cfg_wdata[rzs_pkg::ZCNT_W-1:0];
        rzs_pkg::REG_LIMITS_LOW:  limits_low   <= cfg_wdata;
        rzs_pkg::REG_LIMITS_HIGH: limits_high  <= cfg_wdata;
        rzs_pkg::REG_SQUARED:     squared_mode <= cfg_wdata[0];
        rzs_pkg::REG_COLUMNS:     column_count <= cfg_wdata[rzs_pkg::COL_W-1:0];
        rzs_pkg::REG_WRAP:        wrap_columns <= cfg_wdata[rzs_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.zone_count   = zone_count;
    cfg.limits       = {limits_high, limits_low};
    cfg.squared_mode = squared_mode;
    cfg.column_count = column_count;
    cfg.wrap_columns = wrap_columns;
  end

endmodule
`default_nettype wire

// ===== src/rzs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rzs_step (
  input  wire logic     clk,
  input  wire logic     rst,
  input  rzs_pkg::cfg_t  cfg,
  input  wire logic     fire,
  input  rzs_pkg::item_t item,
  output rzs_pkg::result_t res
);

  logic                        scanning,   scanning_next;
  logic [rzs_pkg::COL_W-1:0]   column,     column_next;
  logic [rzs_pkg::DIST_W-1:0]  dist_meas,  dist_meas_next;
  logic [rzs_pkg::DIST_W-1:0]  sq_step,    sq_step_next;
  logic [rzs_pkg::ZONE_W-1:0]  zone_floor, zone_floor_next;

  logic [rzs_pkg::ZCNT_W-1:0]  nz;
  logic [rzs_pkg::ZONE_W-1:0]  far_idx;
  logic [rzs_pkg::DIST_W-1:0]  dist_inc;
  logic [rzs_pkg::ZCNT_W-1:0]  cur;
  logic [rzs_pkg::CELL_W-1:0]  t_off;
  logic [rzs_pkg::MAX_ZONES-1:0] hit;
  logic [rzs_pkg::ZONE_W-1:0]  pick;
  logic [rzs_pkg::COL_W-1:0]   adv_col;
  logic [rzs_pkg::DIST_W-1:0]  adv_dist;
  logic                        at_edge;
  logic                        no_wrap;
  logic [rzs_pkg::DIST_W-1:0]  wrap_add;

  always_comb begin
    if (cfg.zone_count == '0) begin
      nz = rzs_pkg::ZCNT_W'(1);
    end else if (cfg.zone_count > rzs_pkg::ZCNT_W'(rzs_pkg::MAX_ZONES)) begin
      nz = rzs_pkg::ZCNT_W'(rzs_pkg::MAX_ZONES);
    end else begin
      nz = cfg.zone_count;
    end
    far_idx = rzs_pkg::ZONE_W'(nz - rzs_pkg::ZCNT_W'(1));

    dist_inc = (sq_step != '0) ? rzs_pkg::sat_add(dist_meas, sq_step)
                               : rzs_pkg::sat_add(dist_meas, rzs_pkg::DIST_W'(1));

    t_off = item.target_cell - rzs_pkg::CELL_W'(rzs_pkg::ZONE_OFFSET);
    if (item.target_cell == '0) begin
      cur = nz;
    end else if (item.target_cell < rzs_pkg::CELL_W'(rzs_pkg::ZONE_OFFSET)) begin
      cur = '0;
    end else if (t_off > rzs_pkg::CELL_W'(nz)) begin
      cur = nz;
    end else begin
      cur = t_off[rzs_pkg::ZCNT_W-1:0];
    end

    for (int i = 0; i < rzs_pkg::MAX_ZONES; i++) begin
      hit[i] = (rzs_pkg::ZONE_W'(i) >= zone_floor) && (rzs_pkg::ZCNT_W'(i) < cur) &&
               ({{(rzs_pkg::DIST_W-rzs_pkg::LIMIT_W){1'b0}}, cfg.limits[i]} >= dist_inc);
    end
    pick = '0;
    for (int i = rzs_pkg::MAX_ZONES - 1; i >= 0; i--) begin
      if (hit[i]) pick = rzs_pkg::ZONE_W'(i);
    end

    if (item.func == rzs_pkg::FUNC_START) begin
      adv_col  = item.start_column;
      adv_dist = '0;
    end else begin
      adv_col  = column;
      adv_dist = dist_inc;
    end
    at_edge  = ({1'b0, adv_col} + (rzs_pkg::COL_W+1)'(1)) >= {1'b0, cfg.column_count};
    no_wrap  = (cfg.wrap_columns == '0);
    wrap_add = rzs_pkg::sat_add(adv_dist,
                 rzs_pkg::DIST_W'(cfg.wrap_columns - rzs_pkg::COL_W'(1)));

    scanning_next   = scanning;
    column_next     = column;
    dist_meas_next  = dist_meas;
    sq_step_next    = sq_step;
    zone_floor_next = zone_floor;
    res.new_cell     = item.target_cell;
    res.cell_written = 1'b0;
    res.stop_reason  = rzs_pkg::STOP_RUN;

    if (item.func == rzs_pkg::FUNC_START || scanning) begin
      if (item.func == rzs_pkg::FUNC_START) begin
        zone_floor_next = item.start_zone;
        sq_step_next    = cfg.squared_mode ? rzs_pkg::DIST_W'(1) : '0;
        scanning_next   = 1'b1;
        res.new_cell    = '0;
      end
      if (item.func == rzs_pkg::FUNC_CELL && item.source_cell == rzs_pkg::SOURCE_MARK) begin
        scanning_next   = 1'b0;
        res.stop_reason = rzs_pkg::STOP_SOURCE;
      end else if (item.func == rzs_pkg::FUNC_CELL &&
                   dist_inc > {{(rzs_pkg::DIST_W-rzs_pkg::LIMIT_W){1'b0}},
                               cfg.limits[far_idx]}) begin
        dist_meas_next  = dist_inc;
        sq_step_next    = (sq_step != '0) ?
                          rzs_pkg::sat_add(sq_step, rzs_pkg::DIST_W'(2)) : sq_step;
        scanning_next   = 1'b0;
        res.stop_reason = rzs_pkg::STOP_FAR;
      end else begin
        if (item.func == rzs_pkg::FUNC_CELL) begin
          sq_step_next = (sq_step != '0) ?
                         rzs_pkg::sat_add(sq_step, rzs_pkg::DIST_W'(2)) : sq_step;
          if (hit != '0) begin
            res.new_cell     = rzs_pkg::CELL_W'(pick) +
                               rzs_pkg::CELL_W'(rzs_pkg::ZONE_OFFSET);
            res.cell_written = 1'b1;
            zone_floor_next  = pick;
          end
        end
        if (at_edge && no_wrap) begin
          scanning_next   = 1'b0;
          column_next     = cfg.column_count;
          dist_meas_next  = adv_dist;
          res.stop_reason = rzs_pkg::STOP_EDGE;
        end else if (at_edge) begin
          column_next    = '0;
          dist_meas_next = wrap_add;
        end else begin
          column_next    = adv_col + rzs_pkg::COL_W'(1);
          dist_meas_next = adv_dist;
        end
      end
    end
    res.next_column = column_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      column     <= '0;
      dist_meas  <= '0;
      sq_step    <= rzs_pkg::DIST_W'(1);
      zone_floor <= '0;
    end else if (fire) begin
      scanning   <= scanning_next;
      column     <= column_next;
      dist_meas  <= dist_meas_next;
      sq_step    <= sq_step_next;
      zone_floor <= zone_floor_next;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rzs_pkg::*;

  class zone_code_tracker;
    logic [ZCNT_W-1:0]  zone_count;
    logic [LIMIT_W-1:0] limit [MAX_ZONES];
    bit                 squared;
    logic [COL_W-1:0]   columns;
    logic [COL_W-1:0]   wrap;

    bit                 scanning;
    logic [COL_W-1:0]   column;
    logic [DIST_W-1:0]  dist_meas;
    logic [DIST_W-1:0]  step;
    logic [ZONE_W-1:0]  zone_floor;

    result_t            expected_codes [$];
    int                 errors;

    function new();
      zone_count = 1;
      foreach (limit[i]) limit[i] = '0;
      squared    = 1;
      columns    = 1024;
      wrap       = 0;
      scanning   = 0;
      column     = 0;
      dist_meas  = 0;
      step       = 1;
      zone_floor = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ZONE_COUNT:  zone_count = data[ZCNT_W-1:0];
        REG_LIMITS_LOW:  for (int i = 0; i < 4; i++) limit[i] = data[16*i +: 16];
        REG_LIMITS_HIGH: for (int i = 0; i < 4; i++) limit[i+4] = data[16*i +: 16];
        REG_SQUARED:     squared = data[0];
        REG_COLUMNS:     columns = data[COL_W-1:0];
        REG_WRAP:        wrap = data[COL_W-1:0];
        default: ;
      endcase
    endfunction

    function int zones_in_use();
      int n;
      n = zone_count;
      if (n < 1) n = 1;
      if (n > MAX_ZONES) n = MAX_ZONES;
      return n;
    endfunction

    function logic [DIST_W-1:0] add_sat(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    // step one column right; returns 1 on a right edge stop
    function bit move_right();
      if (int'(column) >= int'(columns) - 1) begin
        if (wrap == 0) begin
          scanning = 0;
          column = columns;
          return 1;
        end
        dist_meas = add_sat(dist_meas, DIST_W'(wrap) - DIST_W'(1));
        column = 0;
      end else begin
        column = column + COL_W'(1);
      end
      return 0;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int nz;
      int cur;
      r.new_cell = it.target_cell;
      r.cell_written = 0;
      r.stop_reason = STOP_RUN;
      if (it.func == FUNC_START) begin
        column = it.start_column;
        zone_floor = it.start_zone;
        dist_meas = 0;
        step = squared ? DIST_W'(1) : DIST_W'(0);
        scanning = 1;
        r.new_cell = 0;
        if (move_right()) r.stop_reason = STOP_EDGE;
      end else if (scanning) begin
        nz = zones_in_use();
        if (it.source_cell == SOURCE_MARK) begin
          scanning = 0;
          r.stop_reason = STOP_SOURCE;
        end else begin
          if (step != 0) begin
            dist_meas = add_sat(dist_meas, step);
            step = add_sat(step, DIST_W'(2));
          end else begin
            dist_meas = add_sat(dist_meas, DIST_W'(1));
          end
          if (dist_meas > DIST_W'(limit[nz-1])) begin
            scanning = 0;
            r.stop_reason = STOP_FAR;
          end else begin
            cur = (it.target_cell == 0) ? nz : int'(it.target_cell) - ZONE_OFFSET;
            if (cur > nz) cur = nz;
            for (int i = zone_floor; i < cur; i++) begin
              if (DIST_W'(limit[i]) >= dist_meas) begin
                r.new_cell = CELL_W'(i + ZONE_OFFSET);
                r.cell_written = 1;
                zone_floor = ZONE_W'(i);
                break;
              end
            end
            if (move_right()) r.stop_reason = STOP_EDGE;
          end
        end
      end
      r.next_column = column;
      expected_codes.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      result_t e;
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, data);
        return;
      end
      e = expected_codes.pop_front();
      compare_field("new_cell", e.new_cell, data[7:0]);
      compare_field("cell_written", e.cell_written, data[8]);
      compare_field("next_column", e.next_column, data[24:9]);
      compare_field("stop_reason", e.stop_reason, data[26:25]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  zone_code_tracker tracker;
  int gap_pct;
  int stall_pct;
  int hold_len;
  int hold_left;

  raster_zone_scan_right dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("raster_zone_scan_right: mismatch");
    $finish;
  end

  // receive side: check each transfer, then pick the next ready
  initial begin
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) tracker.check_result(m_tdata);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic item_t mk(logic func, int col, int fz, int src, int tgt);
    item_t it;
    it.func = func;
    it.start_column = COL_W'(col);
    it.start_zone = ZONE_W'(fz);
    it.source_cell = CELL_W'(src);
    it.target_cell = CELL_W'(tgt);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    s_tvalid <= 1'b1;
    s_tuser <= it.func;
    s_tdata <= {5'b0, it.target_cell, it.source_cell, it.start_zone, it.start_column};
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_item(it);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.expected_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_zones(input int zc, input logic [63:0] lo, input logic [63:0] hi,
                            input bit sq, input int cc, input int wr);
    write_reg(REG_ZONE_COUNT, 64'(zc));
    write_reg(REG_LIMITS_LOW, lo);
    write_reg(REG_LIMITS_HIGH, hi);
    write_reg(REG_SQUARED, 64'(sq));
    write_reg(REG_COLUMNS, 64'(cc));
    write_reg(REG_WRAP, 64'(wr));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    int cc;
    int top;
    int nz;
    cc = tracker.columns;
    nz = tracker.zones_in_use();
    it.start_column = COL_W'($urandom);
    it.start_zone = ZONE_W'($urandom);
    it.source_cell = CELL_W'($urandom);
    it.target_cell = CELL_W'($urandom);
    if (!tracker.scanning) it.func = ($urandom_range(99) < 85) ? FUNC_START : FUNC_CELL;
    else it.func = ($urandom_range(99) < 4) ? FUNC_START : FUNC_CELL;
    top = (cc < 2) ? 65534 : ((cc - 1 > 65534) ? 65534 : cc - 1);
    case ($urandom_range(4))
      0: it.start_column = COL_W'($urandom_range(65534, 0));
      1: it.start_column = COL_W'($urandom_range(top, (top >= 2) ? top - 2 : 0));
      2: it.start_column = COL_W'($urandom_range(top, 0));
      default: it.start_column = COL_W'($urandom_range(3, 0));
    endcase
    if ($urandom_range(1)) it.start_zone = 0;
    if ($urandom_range(99) < 3) it.source_cell = SOURCE_MARK;
    else if (it.source_cell == SOURCE_MARK) it.source_cell = 0;
    case ($urandom_range(5))
      0, 1: it.target_cell = 0;
      2, 3: it.target_cell = CELL_W'(ZONE_OFFSET + $urandom_range(nz - 1, 0));
      4: it.target_cell = CELL_W'($urandom_range(ZONE_OFFSET - 1, 1));
      default: ;
    endcase
    return it;
  endfunction

  task automatic run_phase(input int mode, input int count);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 51; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 51; end
      default: begin gap_pct = 16; stall_pct = 16; end
    endcase
    for (int n = 0; n < count; n++) begin
      if (mode == 2 && n == 20) hold_len = 80;
      if (mode == 3 && n == 40) drain();
      send_item(random_item());
    end
    drain();
  endtask

  initial begin
    tracker = new();
    gap_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_zones(4, {16'd4, 16'd3, 16'd2, 16'd1}, 64'd0, 1'b0, 64, 0);
    send_item(mk(FUNC_START, 0, 0, 0, 0));
    send_item(mk(FUNC_CELL, 0, 0, 0, 0));
    send_item(mk(FUNC_CELL, 0, 0, 255, 255));
    send_item(mk(FUNC_CELL, 0, 0, 0, 1));
    send_item(mk(FUNC_CELL, 0, 0, 0, 3));
    send_item(mk(FUNC_CELL, 0, 0, 0, 0));
    send_item(mk(FUNC_CELL, 0, 0, 0, 8'h5a));
    send_item(mk(FUNC_START, 62, 7, 0, 0));
    send_item(mk(FUNC_CELL, 0, 0, 0, 0));
    send_item(mk(FUNC_START, 63, 0, 0, 0));
    send_item(mk(FUNC_START, 65534, 3, 255, 255));
    send_item(mk(FUNC_START, 10, 0, 0, 0));
    send_item(mk(FUNC_CELL, 0, 0, 1, 0));
    send_item(mk(FUNC_START, 5, 2, 0, 0));
    send_item(mk(FUNC_CELL, 65535, 7, 2, 0));
    send_item(mk(FUNC_CELL, 0, 0, 0, 4));
    send_item(mk(FUNC_CELL, 0, 0, 0, 255));
    send_item(mk(FUNC_CELL, 0, 0, 0, 2));
    drain();

    load_zones(4, {16'd40, 16'd20, 16'd8, 16'd3}, 64'd0, 1'b0, 64, 0);
    run_phase(0, 85);
    load_zones(8, {16'd200, 16'd50, 16'd9, 16'd1}, {16'd3000, 16'd1500, 16'd800, 16'd400},
               1'b1, 30, 20);
    run_phase(1, 85);
    load_zones(0, 64'd100, 64'd0, 1'b0, 2, 0);
    run_phase(2, 85);
    load_zones(15, {64{1'b1}}, {64{1'b1}}, 1'b0, 65535, 65535);
    run_phase(3, 85);
    load_zones(6, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 0, 3);
    run_phase(0, 85);
    load_zones(5, {16'd10, 16'd6, 16'd4, 16'd2}, {48'd0, 16'd30}, 1'b0, 1, 0);
    run_phase(1, 85);
    load_zones(8, {16'd20, 16'd15, 16'd10, 16'd5}, {16'd40, 16'd35, 16'd30, 16'd25},
               1'b0, 16, 1);
    run_phase(2, 85);
    load_zones(3, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1000, 0);
    run_phase(3, 85);

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_codes.size() == 0) begin
      $display("raster_zone_scan_right: match");
    end else begin
      $display("raster_zone_scan_right: mismatch");
    end
    $finish;
  end

endmodule
